@@ src/ffsa_pkg.sv @@
package ffsa_pkg;

	localparam int WORD_BITS = 16;
	localparam int BIT_W     = 4;
	localparam int SIZE_W    = 16;
	localparam int IDX_W     = 8;
	localparam int CHG_W     = 9;
	localparam int NUM_W     = SIZE_W + 1;

	localparam logic OP_ALLOC    = 1'b0;
	localparam logic OP_FREE     = 1'b1;
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_DISPATCH,
		ST_SCAN,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_FINISH
	} ffsa_state_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_FAIL,
		RES_ALLOC,
		RES_FIRST,
		RES_FREED
	} ffsa_res_t;

	typedef struct packed {
		logic      load;
		logic      mul;
		logic      clr_wr;
		logic      scan_init;
		logic      scan_step;
		logic      mark_wr;
		logic      free_init;
		logic      free_wr;
		logic      out_load;
		ffsa_res_t res_sel;
	} ffsa_cmd_t;

	typedef struct packed {
		logic is_free;
		logic oob;
		logic too_big;
		logic need_zero;
		logic scan_hit;
		logic w_last;
		logic mark_last;
		logic free_more;
	} ffsa_sts_t;

endpackage

@@ src/ffsa_req_if.sv @@
interface ffsa_req_if import ffsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [SIZE_W-1:0] size_bytes;
	logic [IDX_W-1:0]  slot_index;

	modport source (output valid, output op, output size_bytes, output slot_index, input ready);
	modport sink (input valid, input op, input size_bytes, input slot_index, output ready);
endinterface

@@ src/ffsa_rsp_if.sv @@
interface ffsa_rsp_if import ffsa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             status;
	logic [IDX_W-1:0] start_slot;
	logic [CHG_W-1:0] slots_changed;

	modport source (output valid, output status, output start_slot, output slots_changed,
		input ready);
	modport sink (input valid, input status, input start_slot, input slots_changed,
		output ready);
endinterface

@@ src/ffsa_ctrl.sv @@
module ffsa_ctrl import ffsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  ffsa_sts_t sts,
	output ffsa_cmd_t cmd
);

	ffsa_state_t state_q, state_d;
	ffsa_res_t   res_q, res_d;
	logic        out_valid_q, out_valid_d;
	logic        out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			res_q       <= RES_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_q       <= res_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state
	always_comb begin
		state_d     = state_q;
		res_d       = res_q;
		out_valid_d = out_valid_q && !rsp_ready;
		case (state_q)
			ST_CLEAR: begin
				if (sts.w_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (sts.is_free) begin
					if (sts.oob) begin
						res_d   = RES_NONE;
						state_d = ST_FINISH;
					end else begin
						state_d = ST_FREE_RD;
					end
				end else if (sts.too_big) begin
					res_d   = RES_FAIL;
					state_d = ST_FINISH;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_hit) begin
					if (sts.need_zero) begin
						res_d   = RES_FIRST;
						state_d = ST_FINISH;
					end else begin
						res_d   = RES_ALLOC;
						state_d = ST_MARK_RD;
					end
				end else if (sts.w_last) begin
					res_d   = RES_FAIL;
					state_d = ST_FINISH;
				end
			end
			ST_MARK_RD: begin
				state_d = ST_MARK_WR;
			end
			ST_MARK_WR: begin
				state_d = sts.mark_last ? ST_FINISH : ST_MARK_RD;
			end
			ST_FREE_RD: begin
				state_d = ST_FREE_WR;
			end
			ST_FREE_WR: begin
				if (sts.free_more) begin
					state_d = ST_FREE_RD;
				end else begin
					res_d   = RES_FREED;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd         = '0;
		cmd.res_sel = res_q;
		req_ready   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_DISPATCH: begin
				cmd.free_init = sts.is_free && !sts.oob;
				cmd.scan_init = !sts.is_free && !sts.too_big;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_MARK_WR: begin
				cmd.mark_wr = 1'b1;
			end
			ST_FREE_WR: begin
				cmd.free_wr = 1'b1;
			end
			ST_FINISH: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ src/ffsa_datapath.sv @@
module ffsa_datapath import ffsa_pkg::*; #(
	parameter int POOL_SLOTS = 256,
	parameter int SLOT_BYTES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ffsa_cmd_t         cmd,
	output ffsa_sts_t         sts,
	input  logic              req_op,
	input  logic [SIZE_W-1:0] req_size_bytes,
	input  logic [IDX_W-1:0]  req_slot_index,
	output logic              rsp_status,
	output logic [IDX_W-1:0]  rsp_start_slot,
	output logic [CHG_W-1:0]  rsp_slots_changed
);

	localparam int WORDS  = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SA_W   = WA_W + BIT_W;
	localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
	localparam int RUN_W  = $clog2(POOL_SLOTS + WORD_BITS + 1);
	localparam int MEM_W  = 2 * WORD_BITS;
	localparam int RCP_SH = NUM_W + $clog2(SLOT_BYTES);
	localparam int RCP_W  = NUM_W + 1;
	localparam int PROD_W = NUM_W + RCP_W;

	localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(WORDS - 1);
	localparam logic [RCP_W-1:0] RECIP =
		RCP_W'(((longint'(1) << RCP_SH) + longint'(SLOT_BYTES) - 1) / longint'(SLOT_BYTES));
	localparam logic [NUM_W-1:0] BYTES_M1 = NUM_W'(SLOT_BYTES - 1);
	localparam logic [NUM_W-1:0] POOL_N   = NUM_W'(POOL_SLOTS);
	localparam logic [SA_W:0]    POOL_SA  = (SA_W + 1)'(POOL_SLOTS);

	logic [MEM_W-1:0] mem [WORDS];
	logic [MEM_W-1:0] rd_q;
	logic [WA_W-1:0]  rd_addr;
	logic             wr_en;
	logic [MEM_W-1:0] wr_data;

	logic              op_q;
	logic [SIZE_W-1:0] size_q;
	logic [IDX_W-1:0]  slot_q;
	logic [PROD_W-1:0] prod_q;
	logic [WA_W-1:0]   w_q;
	logic [BIT_W-1:0]  b_q;
	logic              first_q;
	logic [RUN_W-1:0]  run_q;
	logic [SA_W-1:0]   start_q;
	logic [SA_W-1:0]   run_end_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [NUM_W-1:0]       need;
	logic [NUM_W-1:0]       slot_n;
	logic [SA_W+IDX_W-1:0]  slot_wide;
	logic [SA_W-1:0]        slot_sa;
	logic [WORD_BITS-1:0]   fr, cn, fv, hit, mk, st, fm, c2;
	logic [RUN_W-1:0]       len [WORD_BITS];
	logic                   hit_any;
	logic [BIT_W-1:0]       hit_bit;
	logic [SA_W-1:0]        end_pos, start_pos;
	logic [NUM_W-1:0]       start_n;
	logic [WA_W-1:0]        w_next;

	assign fr      = rd_q[WORD_BITS-1:0];
	assign cn      = rd_q[MEM_W-1:WORD_BITS];
	assign need    = NUM_W'(prod_q >> RCP_SH);
	assign slot_n  = NUM_W'(slot_q);
	assign slot_wide = (SA_W + IDX_W)'(slot_q);
	assign slot_sa = slot_wide[SA_W-1:0];
	assign w_next  = (w_q == LAST_WORD) ? w_q : w_q + 1'b1;

	// scan evaluation of one bitmap word
	always_comb begin
		logic [SA_W-1:0] pos;
		fv = '0;
		for (int k = 0; k < WORD_BITS; k++) begin
			pos   = {w_q, BIT_W'(k)};
			fv[k] = fr[k] && ({1'b0, pos} < POOL_SA);
		end
		for (int j = 0; j < WORD_BITS; j++) begin
			len[j] = run_q + RUN_W'(j + 1);
			for (int k = 0; k <= j; k++) begin
				if (!fv[k]) len[j] = RUN_W'(j - k);
			end
			hit[j] = (need == '0) ? fv[j] : (NUM_W'(len[j]) >= need);
		end
		hit_any = |hit;
		hit_bit = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (hit[j]) hit_bit = BIT_W'(j);
		end
		end_pos   = {w_q, hit_bit};
		start_n   = NUM_W'(end_pos) + NUM_W'(1) - need;
		start_pos = (need == '0) ? end_pos : start_n[SA_W-1:0];
	end

	// run marking and free walk masks
	always_comb begin
		logic [SA_W-1:0]      pos;
		logic [BIT_W-1:0]     beff;
		logic [WORD_BITS-1:0] lowk;
		mk = '0;
		st = '0;
		fm = '0;
		c2 = cn;
		for (int k = 0; k < WORD_BITS; k++) begin
			pos   = {w_q, BIT_W'(k)};
			mk[k] = (pos >= start_q) && (pos <= run_end_q);
			st[k] = (pos == start_q);
			if (first_q && (BIT_W'(k) <= b_q)) c2[k] = 1'b1;
		end
		beff = first_q ? b_q : '0;
		for (int k = 0; k < WORD_BITS; k++) begin
			lowk  = WORD_BITS'((32'd1 << (k + 1)) - 32'd1);
			fm[k] = (BIT_W'(k) >= beff) && ((c2 & lowk) == lowk);
		end
	end

	always_comb begin
		rd_addr = w_q;
		if (cmd.scan_init) rd_addr = '0;
		else if (cmd.scan_step) rd_addr = w_next;
	end

	always_comb begin
		wr_en   = cmd.clr_wr || cmd.mark_wr || cmd.free_wr;
		wr_data = {{WORD_BITS{1'b0}}, {WORD_BITS{1'b1}}};
		if (cmd.mark_wr) wr_data = {(cn & ~mk) | (mk & ~st), fr & ~mk};
		else if (cmd.free_wr) wr_data = {cn & ~fm, fr | fm};
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[w_q] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
		end else begin
			if (cmd.clr_wr || cmd.mark_wr || cmd.free_wr) w_q <= w_q + 1'b1;
			else if (cmd.scan_init) w_q <= '0;
			else if (cmd.free_init) w_q <= slot_sa[SA_W-1:BIT_W];
			else if (cmd.scan_step) w_q <= hit_any ? start_pos[SA_W-1:BIT_W] : w_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req_op;
			size_q <= req_size_bytes;
			slot_q <= req_slot_index;
		end
		if (cmd.mul) prod_q <= PROD_W'(NUM_W'(size_q) + BYTES_M1) * PROD_W'(RECIP);
		if (cmd.scan_init) run_q <= '0;
		if (cmd.scan_step) begin
			run_q <= len[WORD_BITS-1];
			if (hit_any) begin
				start_q   <= start_pos;
				run_end_q <= end_pos;
			end
		end
		if (cmd.free_init) begin
			b_q     <= slot_sa[BIT_W-1:0];
			first_q <= 1'b1;
			cnt_q   <= '0;
		end
		if (cmd.free_wr) begin
			first_q <= 1'b0;
			cnt_q   <= cnt_q + CNT_W'($countones(fm));
		end
	end

	// result register
	always_ff @(posedge clk) begin
		logic [SA_W+IDX_W-1:0]  start_wide;
		logic [CNT_W+CHG_W-1:0] cnt_wide;
		start_wide = (SA_W + IDX_W)'(start_q);
		cnt_wide   = (CNT_W + CHG_W)'(cnt_q);
		if (cmd.out_load) begin
			rsp_status        <= STATUS_DONE;
			rsp_start_slot    <= '0;
			rsp_slots_changed <= '0;
			case (cmd.res_sel)
				RES_FAIL: begin
					rsp_status <= STATUS_FAIL;
				end
				RES_ALLOC: begin
					rsp_start_slot    <= start_wide[IDX_W-1:0];
					rsp_slots_changed <= need[CHG_W-1:0];
				end
				RES_FIRST: begin
					rsp_start_slot <= start_wide[IDX_W-1:0];
				end
				RES_FREED: begin
					rsp_slots_changed <= cnt_wide[CHG_W-1:0];
				end
				default: begin
					rsp_status <= STATUS_DONE;
				end
			endcase
		end
	end

	always_comb begin
		sts           = '0;
		sts.is_free   = (op_q == OP_FREE);
		sts.oob       = slot_n >= POOL_N;
		sts.too_big   = need > POOL_N;
		sts.need_zero = (need == '0);
		sts.scan_hit  = hit_any;
		sts.w_last    = (w_q == LAST_WORD);
		sts.mark_last = (w_q == run_end_q[SA_W-1:BIT_W]);
		sts.free_more = fm[WORD_BITS-1] && (w_q != LAST_WORD);
	end

endmodule

@@ src/first_fit_slot_allocator.sv @@
// First-fit slot allocator over a pool of POOL_SLOTS slots of SLOT_BYTES bytes.
// req channel (sink): op 0 allocates size_bytes rounded up to whole slots,
// op 1 frees the run starting at slot_index. rsp channel (source): one response
// per request with status, start_slot and slots_changed.
// Requests are taken one at a time; ready is high only while the block is idle.
// The free and continuation bitmaps live in one memory of ceil(POOL_SLOTS/16) 16-slot words.
// Sequence: an allocate is accepted, converts its size to slots, dispatches, scans
// the bitmap words (one per cycle, up to every word of the memory), then reads and writes
// each word the new run covers (none for zero size) and finishes; a free reads and
// writes each word it walks, then finishes. The response turns valid as the block
// returns to idle, where the next request can be accepted; a new request is not
// taken before the last one is through. Too-large allocates and out-of-range frees go straight to finish.
// After reset every word of the memory is swept, one word a cycle,
// before the first request is taken.
// The response sits in an output register; if the receiver stalls, the block
// still takes the next request and holds its finished response until the
// register empties.
module first_fit_slot_allocator import ffsa_pkg::*; #(
	parameter int POOL_SLOTS = 256,
	parameter int SLOT_BYTES = 4
) (
	input logic      clk,
	input logic      arst_n,
	ffsa_req_if.sink   req,
	ffsa_rsp_if.source rsp
);

	ffsa_cmd_t cmd;
	ffsa_sts_t sts;

	ffsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffsa_datapath #(
		.POOL_SLOTS (POOL_SLOTS),
		.SLOT_BYTES (SLOT_BYTES)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.req_op            (req.op),
		.req_size_bytes    (req.size_bytes),
		.req_slot_index    (req.slot_index),
		.rsp_status        (rsp.status),
		.rsp_start_slot    (rsp.start_slot),
		.rsp_slots_changed (rsp.slots_changed)
	);

endmodule
